// ===== sv/sbdb_pkg.sv =====
package sbdb_pkg;

  // field widths
  localparam int BIN_W    = 27;
  localparam int IDX_W    = 9;
  localparam int CFG_W    = 18;
  localparam int LEFT_W   = 19;
  localparam int BOTTOM_W = 18;
  localparam int BARW_W   = 9;
  localparam int HEIGHT_W = 18;
  localparam int COLOR_W  = 17;

  // magnitude and log path widths
  localparam int ROOT_IN_W = 56;
  localparam int ROOT_W    = 29;
  localparam int LOG_W     = 21;

  // Q16 constants
  localparam logic [COLOR_W-1:0] Q_ONE   = 17'd65536;
  localparam logic [COLOR_W-1:0] M_FLOOR = 17'd65;
  localparam logic [12:0]        LOG_K   = 13'd6576;

  // register indexes on the config port
  localparam logic [1:0] REG_OFFSET_X       = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y       = 2'd1;
  localparam logic [1:0] REG_DISPLAY_WIDTH  = 2'd2;
  localparam logic [1:0] REG_DISPLAY_HEIGHT = 2'd3;

  localparam logic [CFG_W-1:0] DISPLAY_RESET = 18'd131072;

endpackage

// ===== sv/sbdb_if.sv =====
interface sbdb_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [sbdb_pkg::BIN_W-1:0] bin_real;
  logic signed [sbdb_pkg::BIN_W-1:0] bin_imag;
  logic [sbdb_pkg::IDX_W-1:0]        bin_index;

  modport source(output valid, bin_real, bin_imag, bin_index, input ready);
  modport sink(input valid, bin_real, bin_imag, bin_index, output ready);
endinterface

interface sbdb_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sbdb_pkg::LEFT_W-1:0]   bar_left_x;
  logic signed [sbdb_pkg::BOTTOM_W-1:0] bar_bottom_y;
  logic [sbdb_pkg::BARW_W-1:0]          bar_width;
  logic [sbdb_pkg::HEIGHT_W-1:0]        bar_height;
  logic [sbdb_pkg::COLOR_W-1:0]         color_red;
  logic [sbdb_pkg::COLOR_W-1:0]         color_blue;

  modport source(output valid, bar_left_x, bar_bottom_y, bar_width, bar_height,
                 color_red, color_blue, input ready);
  modport sink(input valid, bar_left_x, bar_bottom_y, bar_width, bar_height,
               color_red, color_blue, output ready);
endinterface

// ===== sv/sbdb_isqrt.sv =====
module sbdb_isqrt #(
  parameter int SW = 9
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic [sbdb_pkg::ROOT_IN_W-1:0]     in_n,
  input  logic [SW-1:0]                      in_side,
  output logic                               out_valid,
  output logic [sbdb_pkg::ROOT_W-1:0]        out_root,
  output logic [SW-1:0]                      out_side
);

  localparam int NW    = sbdb_pkg::ROOT_IN_W;
  localparam int STEPS = NW / 2;

  logic [NW-1:0] n_r    [STEPS];
  logic [NW-1:0] res_r  [STEPS];
  logic [SW-1:0] side_r [STEPS];
  logic          v_r    [STEPS];

  // one result bit per stage, highest first
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam int K = STEPS - 1 - j;
    logic [NW-1:0] n_in, res_in, trial, n_nxt, res_nxt;
    logic [SW-1:0] side_in;
    logic          v_in;

    if (j == 0) begin : g_first
      assign n_in    = in_n;
      assign res_in  = '0;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign n_in    = n_r[j-1];
      assign res_in  = res_r[j-1];
      assign side_in = side_r[j-1];
      assign v_in    = v_r[j-1];
    end

    always_comb begin
      trial = res_in + (NW'(1) << (2 * K));
      if (n_in >= trial) begin
        n_nxt   = n_in - trial;
        res_nxt = (res_in >> 1) + (NW'(1) << (2 * K));
      end else begin
        n_nxt   = n_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
      if (en) begin
        n_r[j]    <= n_nxt;
        res_r[j]  <= res_nxt;
        side_r[j] <= side_in;
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_root  = res_r[STEPS-1][sbdb_pkg::ROOT_W-1:0];
  assign out_side  = side_r[STEPS-1];

endmodule

// ===== sv/sbdb_log2.sv =====
module sbdb_log2 #(
  parameter int SW = 26
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [sbdb_pkg::COLOR_W-1:0]     in_m,
  input  logic [SW-1:0]                    in_side,
  output logic                             out_valid,
  output logic [sbdb_pkg::LOG_W-1:0]       out_log,
  output logic [SW-1:0]                    out_side
);

  localparam int FB    = 16;
  localparam int YW    = 31;
  localparam int NST   = FB + 1;

  logic [YW-1:0] y_r    [NST];
  logic [FB-1:0] f_r    [NST];
  logic [4:0]    p_r    [NST];
  logic [SW-1:0] side_r [NST];
  logic          v_r    [NST];

  // normalize: integer part and Q30 mantissa
  logic [4:0]    p0;
  logic [YW-1:0] y0;

  always_comb begin
    p0 = '0;
    for (int i = 0; i < sbdb_pkg::COLOR_W; i++) begin
      if (in_m[i]) p0 = 5'(i);
    end
    y0 = YW'(in_m) << (5'd30 - p0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      y_r[0]    <= y0;
      f_r[0]    <= '0;
      p_r[0]    <= p0;
      side_r[0] <= in_side;
    end
  end

  // one fraction bit per stage by squaring the mantissa
  for (genvar j = 1; j < NST; j++) begin : g_sq
    logic [2*YW-1:0] sq;
    logic [YW:0]     t;
    logic [YW-1:0]   y_nxt;

    always_comb begin
      sq    = {{YW{1'b0}}, y_r[j-1]} * {{YW{1'b0}}, y_r[j-1]};
      t     = sq[2*YW-1:YW-1];
      y_nxt = t[YW] ? t[YW:1] : t[YW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_r[j-1];
      end
      if (en) begin
        y_r[j]    <= y_nxt;
        f_r[j]    <= {f_r[j-1][FB-2:0], t[YW]};
        p_r[j]    <= p_r[j-1];
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign out_log   = {p_r[NST-1], f_r[NST-1]};
  assign out_side  = side_r[NST-1];

endmodule

// ===== sv/spectrum_bin_to_db_bar_unit.sv =====
// Maps one complex FFT bin per beat to one display bar (position, size, color),
// all in Q16. A new bin can be taken every cycle unless the output stalls. Each bin
// passes 52 register stages: 3 front-end, the 28-stage square root, the clamp,
// the 17-stage log2 and 3 back-end stages. The whole pipeline advances together:
// it moves whenever the output register is empty or being taken, so a stall at
// the output holds every stage.
// NUM_SAMPLES must be a power of two. Config registers are byte-addressed at
// 0, 4, 8, 12: offset_x, offset_y, display_width, display_height.
module spectrum_bin_to_db_bar_unit #(
  parameter int NUM_SAMPLES = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  sbdb_in_if.sink      in_bin,
  sbdb_out_if.source   out_bar,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int SHIFT = $clog2(NUM_SAMPLES);
  localparam int CW    = sbdb_pkg::CFG_W;
  localparam int MW    = sbdb_pkg::COLOR_W;
  localparam int IW    = sbdb_pkg::IDX_W;
  localparam int BW    = sbdb_pkg::BIN_W;

  // config registers
  logic [CW-1:0] offset_x_r, offset_y_r, display_width_r, display_height_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r       <= '0;
      offset_y_r       <= '0;
      display_width_r  <= sbdb_pkg::DISPLAY_RESET;
      display_height_r <= sbdb_pkg::DISPLAY_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[3:2])
        sbdb_pkg::REG_OFFSET_X:       offset_x_r       <= cfg_pwdata[CW-1:0];
        sbdb_pkg::REG_OFFSET_Y:       offset_y_r       <= cfg_pwdata[CW-1:0];
        sbdb_pkg::REG_DISPLAY_WIDTH:  display_width_r  <= cfg_pwdata[CW-1:0];
        sbdb_pkg::REG_DISPLAY_HEIGHT: display_height_r <= cfg_pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      sbdb_pkg::REG_OFFSET_X:       cfg_prdata = 32'(offset_x_r);
      sbdb_pkg::REG_OFFSET_Y:       cfg_prdata = 32'(offset_y_r);
      sbdb_pkg::REG_DISPLAY_WIDTH:  cfg_prdata = 32'(display_width_r);
      sbdb_pkg::REG_DISPLAY_HEIGHT: cfg_prdata = 32'(display_height_r);
      default:                      cfg_prdata = '0;
    endcase
  end

  // global advance
  logic out_valid_r, en;
  assign en           = !out_valid_r || out_bar.ready;
  assign in_bin.ready = en;

  // stage a: absolute values
  logic          va_r, vb_r, vc_r;
  logic [BW-1:0] are_r, aim_r;
  logic [IW-1:0] idx_a_r, idx_b_r, idx_c_r;

  // stage b: squares, stage c: 4*s
  logic [2*BW-1:0]                  sqr_r, sqi_r;
  logic [sbdb_pkg::ROOT_IN_W-1:0]   n4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_bin.valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
    if (en) begin
      are_r   <= in_bin.bin_real[BW-1] ? BW'(-in_bin.bin_real) : BW'(in_bin.bin_real);
      aim_r   <= in_bin.bin_imag[BW-1] ? BW'(-in_bin.bin_imag) : BW'(in_bin.bin_imag);
      idx_a_r <= in_bin.bin_index;
      sqr_r   <= {{BW{1'b0}}, are_r} * {{BW{1'b0}}, are_r};
      sqi_r   <= {{BW{1'b0}}, aim_r} * {{BW{1'b0}}, aim_r};
      idx_b_r <= idx_a_r;
      n4_r    <= (sbdb_pkg::ROOT_IN_W'(sqr_r) + sbdb_pkg::ROOT_IN_W'(sqi_r)) << 2;
      idx_c_r <= idx_b_r;
    end
  end

  // square root pipeline
  logic                        vq;
  logic [sbdb_pkg::ROOT_W-1:0] root;
  logic [IW-1:0]               idx_q;

  sbdb_isqrt #(.SW(IW)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (vc_r),
    .in_n     (n4_r),
    .in_side  (idx_c_r),
    .out_valid(vq),
    .out_root (root),
    .out_side (idx_q)
  );

  // scale by 2/N and clamp to [0.001, 1.0]
  logic [sbdb_pkg::ROOT_W-1:0] m_full;
  logic [MW-1:0]               m_cl, m_r;
  logic                        vm_r;
  logic [IW-1:0]               idx_m_r;

  always_comb begin
    m_full = root >> SHIFT;
    if (m_full < sbdb_pkg::ROOT_W'(sbdb_pkg::M_FLOOR)) begin
      m_cl = sbdb_pkg::M_FLOOR;
    end else if (m_full > sbdb_pkg::ROOT_W'(sbdb_pkg::Q_ONE)) begin
      m_cl = sbdb_pkg::Q_ONE;
    end else begin
      m_cl = m_full[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (en) begin
      vm_r <= vq;
    end
    if (en) begin
      m_r     <= m_cl;
      idx_m_r <= idx_q;
    end
  end

  // log2 pipeline, magnitude and index ride along
  logic                       vl;
  logic [sbdb_pkg::LOG_W-1:0] lg;
  logic [MW+IW-1:0]           side_l;

  sbdb_log2 #(.SW(MW + IW)) u_log2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (vm_r),
    .in_m     (m_r),
    .in_side  ({m_r, idx_m_r}),
    .out_valid(vl),
    .out_log  (lg),
    .out_side (side_l)
  );

  // drop in dB scale
  logic [sbdb_pkg::LOG_W-1:0] negl;
  logic [33:0]                drop_prod;
  logic [17:0]                drop_r;
  logic                       vd_r, vh_r;
  logic [MW+IW-1:0]           side_d_r, side_h_r;
  logic [MW-1:0]              h_r;

  always_comb begin
    negl      = sbdb_pkg::LOG_W'(21'd1 << 20) - lg;
    drop_prod = 34'(negl) * 34'(sbdb_pkg::LOG_K) + 34'd32768;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      vh_r <= 1'b0;
    end else if (en) begin
      vd_r <= vl;
      vh_r <= vd_r;
    end
    if (en) begin
      drop_r   <= drop_prod[33:16];
      side_d_r <= side_l;
      h_r      <= (drop_r > 18'(sbdb_pkg::Q_ONE)) ? '0
                  : MW'(18'(sbdb_pkg::Q_ONE) - drop_r);
      side_h_r <= side_d_r;
    end
  end

  // output stage: height scale and bar geometry
  logic [MW-1:0]   m_h;
  logic [IW-1:0]   idx_h;
  logic [34:0]     hprod;
  logic [CW-1:0]   dx;
  logic [26:0]     xprod;

  always_comb begin
    m_h   = side_h_r[MW+IW-1:IW];
    idx_h = side_h_r[IW-1:0];
    hprod = 35'(h_r) * 35'(display_height_r);
    dx    = display_width_r >> (SHIFT - 1);
    xprod = 27'(dx) * 27'(idx_h);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vh_r;
    end
    if (en) begin
      out_bar.bar_left_x   <= sbdb_pkg::LEFT_W'(xprod) + sbdb_pkg::LEFT_W'(offset_x_r)
                              - sbdb_pkg::LEFT_W'(sbdb_pkg::Q_ONE);
      out_bar.bar_bottom_y <= sbdb_pkg::BOTTOM_W'(offset_y_r)
                              - sbdb_pkg::BOTTOM_W'(sbdb_pkg::Q_ONE);
      out_bar.bar_width    <= dx[sbdb_pkg::BARW_W-1:0];
      out_bar.bar_height   <= hprod[33:16];
      out_bar.color_red    <= sbdb_pkg::Q_ONE - m_h;
      out_bar.color_blue   <= m_h;
    end
  end

  assign out_bar.valid = out_valid_r;

  // colors always sum to full scale
  a_color_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_bar.color_red + out_bar.color_blue == sbdb_pkg::Q_ONE))
    else $error("red and blue do not sum to one");

  // blue stays within clamp limits
  a_blue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_bar.color_blue >= sbdb_pkg::M_FLOOR &&
                     out_bar.color_blue <= sbdb_pkg::Q_ONE))
    else $error("magnitude out of clamp range");

  // an accepted beat enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bin.valid && in_bin.ready) |=> va_r)
    else $error("accepted beat lost at pipeline entry");

endmodule

// ===== tb/sv/tb_bar_checker.sv =====
`timescale 1ns / 1ps

module tb_bar_checker #(
  parameter int NUM_SAMPLES = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  sbdb_in_if         in_bin,
  sbdb_out_if        out_bar,
  input  logic [17:0] cur_offset_x,
  input  logic [17:0] cur_offset_y,
  input  logic [17:0] cur_disp_width,
  input  logic [17:0] cur_disp_height,
  output int         fail_count,
  output int         bar_count,
  output int         pending_bars
);

  typedef struct packed {
    logic [sbdb_pkg::LEFT_W-1:0]   left_x;
    logic [sbdb_pkg::BOTTOM_W-1:0] bottom_y;
    logic [sbdb_pkg::BARW_W-1:0]   width;
    logic [sbdb_pkg::HEIGHT_W-1:0] height;
    logic [sbdb_pkg::COLOR_W-1:0]  red;
    logic [sbdb_pkg::COLOR_W-1:0]  blue;
  } bar_t;

  bar_t expected_bars[$];

  // integer square root, bit by bit
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v >>= 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // floor(65536*log2(x)) via repeated squaring of a Q30 mantissa
  function automatic int unsigned log2_fix(input int unsigned x);
    int unsigned p, frac;
    longint unsigned y;
    p = 0;
    frac = 0;
    while (p < 31 && (x >> (p + 1)) != 0) p++;
    y = longint'(x) << (30 - p);
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac <<= 1;
      if (y >= (64'd2 << 30)) begin
        y >>= 1;
        frac |= 1;
      end
    end
    return (p << 16) | frac;
  endfunction

  function automatic bar_t predict_bar(input logic signed [sbdb_pkg::BIN_W-1:0] re,
                                       input logic signed [sbdb_pkg::BIN_W-1:0] im,
                                       input logic [sbdb_pkg::IDX_W-1:0] idx);
    longint unsigned are, aim, mag, negl, drop, h, dx;
    bar_t b;
    are = (re < 0) ? -longint'(re) : longint'(re);
    aim = (im < 0) ? -longint'(im) : longint'(im);
    mag = int_sqrt((are * are + aim * aim) * 4) / NUM_SAMPLES;
    if (mag < 65) mag = 65;
    if (mag > 65536) mag = 65536;
    negl = (64'd16 << 16) - log2_fix(int'(mag));
    drop = (negl * 6576 + 32768) >> 16;
    h = (drop > 65536) ? 0 : 65536 - drop;
    dx = cur_disp_width / (NUM_SAMPLES / 2);
    b.left_x   = sbdb_pkg::LEFT_W'(dx * idx + cur_offset_x - 65536);
    b.bottom_y = sbdb_pkg::BOTTOM_W'(cur_offset_y - 64'd65536);
    b.width    = sbdb_pkg::BARW_W'(dx);
    b.height   = sbdb_pkg::HEIGHT_W'((h * cur_disp_height) >> 16);
    b.red      = sbdb_pkg::COLOR_W'(65536 - mag);
    b.blue     = sbdb_pkg::COLOR_W'(mag);
    return b;
  endfunction

  task automatic report(input string fname, input longint unsigned exp_v,
                        input longint unsigned act_v);
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, exp_v, act_v);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    bar_count = 0;
  end

  assign pending_bars = expected_bars.size();

  // predict on accepted bins, compare on accepted bars
  always @(posedge clk) begin
    bar_t e, a;
    if (rst_n) begin
      if (out_bar.valid && out_bar.ready) begin
        a = '{out_bar.bar_left_x, out_bar.bar_bottom_y, out_bar.bar_width,
              out_bar.bar_height, out_bar.color_red, out_bar.color_blue};
        bar_count++;
        if (expected_bars.size() == 0) begin
          $display("%0t: unexpected bar beat, expected none actual %0h", $time, a);
          fail_count++;
        end else begin
          e = expected_bars.pop_front();
          if (e.left_x != a.left_x) report("bar_left_x", e.left_x, a.left_x);
          if (e.bottom_y != a.bottom_y) report("bar_bottom_y", e.bottom_y, a.bottom_y);
          if (e.width != a.width) report("bar_width", e.width, a.width);
          if (e.height != a.height) report("bar_height", e.height, a.height);
          if (e.red != a.red) report("color_red", e.red, a.red);
          if (e.blue != a.blue) report("color_blue", e.blue, a.blue);
        end
      end
      if (in_bin.valid && in_bin.ready)
        expected_bars.push_back(predict_bar(in_bin.bin_real, in_bin.bin_imag,
                                            in_bin.bin_index));
    end
  end
endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int LATENCY = 52;
  localparam longint CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  logic [17:0] cfg_shadow[4];
  int fail_count, bar_count, pending_bars;
  int bins_sent = 0;
  longint cycle_count = 0;
  bit hold_off = 0;
  bit sink_idle_on = 1;

  sbdb_in_if in_bin();
  sbdb_out_if out_bar();

  spectrum_bin_to_db_bar_unit dut (
    .clk(clk), .rst_n(rst_n), .in_bin(in_bin), .out_bar(out_bar),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  tb_bar_checker chk (
    .clk(clk), .rst_n(rst_n), .in_bin(in_bin), .out_bar(out_bar),
    .cur_offset_x(cfg_shadow[sbdb_pkg::REG_OFFSET_X]),
    .cur_offset_y(cfg_shadow[sbdb_pkg::REG_OFFSET_Y]),
    .cur_disp_width(cfg_shadow[sbdb_pkg::REG_DISPLAY_WIDTH]),
    .cur_disp_height(cfg_shadow[sbdb_pkg::REG_DISPLAY_HEIGHT]),
    .fail_count(fail_count), .bar_count(bar_count), .pending_bars(pending_bars)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 2);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int g;
    out_bar.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_bar.ready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_off = 0;
        out_bar.ready <= 1'b1;
      end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_bar.ready <= 1'b0;
          repeat (g) @(negedge clk);
        end
        out_bar.ready <= 1'b1;
      end else begin
        out_bar.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [17:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= 32'(val);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_shadow[idx] = val;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // valid stays high after a beat so back-to-back beats need no toggle
  task automatic send_bin(input logic [26:0] re, input logic [26:0] im,
                          input logic [8:0] idx, input bit may_gap);
    int g;
    if (may_gap && $urandom_range(0, 2) == 0) begin
      g = gap_len();
      if (g > 0) begin
        in_bin.valid <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
    in_bin.valid <= 1'b1;
    in_bin.bin_real <= re;
    in_bin.bin_imag <= im;
    in_bin.bin_index <= idx;
    do @(posedge clk); while (!in_bin.ready);
    bins_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_bin.valid <= 1'b0;
    while (pending_bars != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  // magnitude spread over all decades; sometimes full-range noise
  function automatic logic [26:0] rand_part();
    int sh;
    logic [26:0] v;
    if ($urandom_range(0, 7) == 0) return 27'($urandom);
    sh = $urandom_range(0, 26);
    v = 27'($urandom) >> sh;
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  initial begin
    logic [17:0] cfg_sets[6][4];
    logic [26:0] dir_re[12], dir_im[12];
    cfg_shadow[sbdb_pkg::REG_OFFSET_X] = 18'd0;
    cfg_shadow[sbdb_pkg::REG_OFFSET_Y] = 18'd0;
    cfg_shadow[sbdb_pkg::REG_DISPLAY_WIDTH] = sbdb_pkg::DISPLAY_RESET;
    cfg_shadow[sbdb_pkg::REG_DISPLAY_HEIGHT] = sbdb_pkg::DISPLAY_RESET;
    in_bin.valid = 1'b0;
    in_bin.bin_real = '0;
    in_bin.bin_imag = '0;
    in_bin.bin_index = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: zero, tiny, floor edge, saturation, field extremes
    dir_re = '{27'd0, 27'd1, 27'd33280, 27'd33792, -27'sd1, 27'h3FFFFFF,
               27'h4000000, 27'd33554432, 27'd5000000, 27'd0, 27'h4000000,
               27'h3FFFFFF};
    dir_im = '{27'd0, 27'd0, 27'd0, 27'd0, -27'sd1, 27'h3FFFFFF,
               27'h4000000, 27'd0, 27'd5000000, 27'h4000000, 27'd0,
               27'h4000000};
    for (int i = 0; i < 12; i++)
      send_bin(dir_re[i], dir_im[i], (i % 2) ? 9'd511 : 9'(i * 40), 0);
    send_bin(27'd0, 27'd0, 9'd0, 0);
    send_bin(27'd1000000, -27'sd1000000, 9'd256, 0);
    drain();

    // config sets, extremes included
    cfg_sets = '{'{18'd0, 18'd0, 18'd0, 18'd0},
                 '{18'd131072, 18'd131072, 18'd131072, 18'd131072},
                 '{18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF},
                 '{18'd65536, 18'd1, 18'd511, 18'd65536},
                 '{18'd0, 18'd0, 18'd0, 18'd0},
                 '{18'd0, 18'd0, 18'd0, 18'd0}};
    for (int k = 0; k < 6; k++) begin
      if (k >= 4)
        for (int r = 0; r < 4; r++) cfg_sets[k][r] = 18'($urandom);
      for (int r = 0; r < 4; r++) write_reg(2'(r), cfg_sets[k][r]);
      if (k == 2) begin
        // long receiver hold-off while bins keep coming
        hold_off = 1;
        sink_idle_on = 0;
        for (int i = 0; i < 150; i++)
          send_bin(rand_part(), rand_part(), 9'($urandom), 0);
        sink_idle_on = 1;
      end
      for (int i = 0; i < 290; i++)
        send_bin(rand_part(), rand_part(), 9'($urandom), i > 60);
      drain();
    end

    $display("covered %0d bins, %0d bars checked, 6 register settings", bins_sent,
             bar_count);
    $display("including a long output stall with the input backed up");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
